@@ rtl/rbs_pkg.sv @@
// Shared types, constants and fixed-point helpers for the ray/box slab test.
// No dependencies; every other file of the block imports this package.
package rbs_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_WIDTH     = 2 * COORD_WIDTH;
   localparam int NUM_AXES       = 3;
   localparam int NUM_REGS       = 2 * NUM_AXES;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REG_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 6 * COORD_WIDTH;
   localparam int RSP_FIELD_BITS = 1 + 2 * COORD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   localparam coord_type COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type COORD_ZERO = '0;

   // Register indexes of the configuration space.
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic s4_en;
      logic s5_en;
   } merge_ctrl_type;

   // Corner minus origin, computed one bit wider and saturated back.
   function automatic coord_type sat_sub(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] d;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      if (d[COORD_WIDTH] != d[COORD_WIDTH-1]) begin
         return d[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
      end
      return d[COORD_WIDTH-1:0];
   endfunction

   // Scales a full product back to the coordinate format. The arithmetic
   // shift rounds toward minus infinity. An infinite reciprocal gives the
   // signed extreme unless the difference is zero.
   function automatic coord_type prod_to_coord(input prod_type p, input logic inf,
                                               input logic zero, input logic neg);
      prod_type s;
      s = p >>> FRAC_BITS;
      if (inf) begin
         if (zero) begin
            return COORD_ZERO;
         end
         return neg ? COORD_MIN : COORD_MAX;
      end
      if ((&s[PROD_WIDTH-1:COORD_WIDTH-1]) || !(|s[PROD_WIDTH-1:COORD_WIDTH-1])) begin
         return s[COORD_WIDTH-1:0];
      end
      return s[PROD_WIDTH-1] ? COORD_MIN : COORD_MAX;
   endfunction

endpackage

@@ rtl/ray_box_slab_intersect_core.sv @@
// Top level of the ray versus axis-aligned box slab test: register port,
// three axis lanes, merge stage and the stream handshake. Depends on rbs_pkg,
// rbs_lane and rbs_merge.
//
//   Channel   Direction  Carries
//   req_*     in         one ray: origin x/y/z, reciprocal direction x/y/z
//   rsp_*     out        hit flag, entry distance, exit distance
//   csr_*     in/out     six box corner registers, byte address 4*index
//
// One ray can transfer every cycle while rsp_tready is high or some stage is empty; a
// stalled result holds rays back once the pipeline is full. A result passes five
// register stages (difference, product, scaled distances, entry and exit, hit); every
// stage is pipelined, so a new ray can enter before the last one has left.
// Every stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up and a stalled result does not block
// input while earlier stages still have room. Reset clears the valid bits and
// sets the box corners to zero.
module ray_box_slab_intersect_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z (low to high)
   input  logic [rbs_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // hit, t_enter, t_exit (low to high), zero filled to whole bytes
   output logic [rbs_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rbs_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [rbs_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [rbs_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import rbs_pkg::*;

   localparam int STAGES = 5;

   coord_type                box_ff [NUM_REGS];
   logic [REG_IDX_WIDTH-1:0] csr_idx;
   logic                     csr_wr;
   logic [STAGES-1:0]        vld_ff, vld_in;
   logic [STAGES-1:0]        adv;
   coord_type                origin [NUM_AXES];
   coord_type                inv_dir [NUM_AXES];
   coord_type                t_min [NUM_AXES];
   coord_type                t_max [NUM_AXES];
   lane_ctrl_type            lane_ctrl;
   merge_ctrl_type           merge_ctrl;
   logic                     hit;
   coord_type                t_enter, t_exit;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_idx < REG_IDX_WIDTH'(NUM_REGS)) begin
         csr_prdata = box_ff[csr_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            box_ff[i] <= COORD_ZERO;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BOX_MIN_X: box_ff[0] <= csr_pwdata;
            REG_BOX_MIN_Y: box_ff[1] <= csr_pwdata;
            REG_BOX_MIN_Z: box_ff[2] <= csr_pwdata;
            REG_BOX_MAX_X: box_ff[3] <= csr_pwdata;
            REG_BOX_MAX_Y: box_ff[4] <= csr_pwdata;
            REG_BOX_MAX_Z: box_ff[5] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or its content moves on.
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
      vld_in[0] = req_tvalid;
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s] = vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   assign req_tready       = adv[0];
   assign lane_ctrl.s1_en  = adv[0];
   assign lane_ctrl.s2_en  = adv[1];
   assign lane_ctrl.s3_en  = adv[2];
   assign merge_ctrl.s4_en = adv[3];
   assign merge_ctrl.s5_en = adv[4];

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      assign origin[k]  = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
      assign inv_dir[k] = req_tdata[(k+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];

      rbs_lane u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .box_lo  (box_ff[k]),
         .box_hi  (box_ff[k+NUM_AXES]),
         .origin  (origin[k]),
         .inv_dir (inv_dir[k]),
         .t_min   (t_min[k]),
         .t_max   (t_max[k])
      );
   end

   rbs_merge u_merge (
      .clock   (clock),
      .ctrl    (merge_ctrl),
      .t_min   (t_min),
      .t_max   (t_max),
      .hit     (hit),
      .t_enter (t_enter),
      .t_exit  (t_exit)
   );

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-RSP_FIELD_BITS){1'b0}}, t_exit, t_enter, hit};

endmodule

@@ rtl/rbs_lane.sv @@
// One axis of the slab test: distances to both box planes, then their order.
// Three register stages: difference, product, scaled minimum and maximum.
// Depends on rbs_pkg.
module rbs_lane (
   input  logic                  clock,
   input  rbs_pkg::lane_ctrl_type ctrl,
   input  rbs_pkg::coord_type    box_lo,
   input  rbs_pkg::coord_type    box_hi,
   input  rbs_pkg::coord_type    origin,
   input  rbs_pkg::coord_type    inv_dir,
   output rbs_pkg::coord_type    t_min,
   output rbs_pkg::coord_type    t_max
);
   import rbs_pkg::*;

   coord_type diff_lo_ff, diff_lo_in;
   coord_type diff_hi_ff, diff_hi_in;
   coord_type inv_ff;
   prod_type  prod_lo_ff, prod_lo_in;
   prod_type  prod_hi_ff, prod_hi_in;
   logic      inf_ff, inf_in;
   logic      zero_lo_ff, zero_lo_in, zero_hi_ff, zero_hi_in;
   logic      neg_lo_ff, neg_lo_in, neg_hi_ff, neg_hi_in;
   coord_type t_lo, t_hi;
   coord_type t_min_ff, t_min_in, t_max_ff, t_max_in;

   assign diff_lo_in = sat_sub(box_lo, origin);
   assign diff_hi_in = sat_sub(box_hi, origin);

   assign prod_lo_in = PROD_WIDTH'(diff_lo_ff) * PROD_WIDTH'(inv_ff);
   assign prod_hi_in = PROD_WIDTH'(diff_hi_ff) * PROD_WIDTH'(inv_ff);
   assign inf_in     = (inv_ff == COORD_MAX) || (inv_ff == COORD_MIN);
   assign zero_lo_in = (diff_lo_ff == COORD_ZERO);
   assign zero_hi_in = (diff_hi_ff == COORD_ZERO);
   assign neg_lo_in  = diff_lo_ff[COORD_WIDTH-1] ^ inv_ff[COORD_WIDTH-1];
   assign neg_hi_in  = diff_hi_ff[COORD_WIDTH-1] ^ inv_ff[COORD_WIDTH-1];

   assign t_lo     = prod_to_coord(prod_lo_ff, inf_ff, zero_lo_ff, neg_lo_ff);
   assign t_hi     = prod_to_coord(prod_hi_ff, inf_ff, zero_hi_ff, neg_hi_ff);
   assign t_min_in = (t_lo < t_hi) ? t_lo : t_hi;
   assign t_max_in = (t_lo < t_hi) ? t_hi : t_lo;

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         diff_lo_ff <= diff_lo_in;
         diff_hi_ff <= diff_hi_in;
         inv_ff     <= inv_dir;
      end
      if (ctrl.s2_en) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         inf_ff     <= inf_in;
         zero_lo_ff <= zero_lo_in;
         zero_hi_ff <= zero_hi_in;
         neg_lo_ff  <= neg_lo_in;
         neg_hi_ff  <= neg_hi_in;
      end
      if (ctrl.s3_en) begin
         t_min_ff <= t_min_in;
         t_max_ff <= t_max_in;
      end
   end

   assign t_min = t_min_ff;
   assign t_max = t_max_ff;

endmodule

@@ rtl/rbs_merge.sv @@
// Combines the lane results: entry is the largest minimum, exit the smallest
// maximum, then the hit decision and the clamp of a negative entry on a hit.
// Depends on rbs_pkg.
module rbs_merge (
   input  logic                   clock,
   input  rbs_pkg::merge_ctrl_type ctrl,
   input  rbs_pkg::coord_type     t_min [rbs_pkg::NUM_AXES],
   input  rbs_pkg::coord_type     t_max [rbs_pkg::NUM_AXES],
   output logic                   hit,
   output rbs_pkg::coord_type     t_enter,
   output rbs_pkg::coord_type     t_exit
);
   import rbs_pkg::*;

   coord_type enter_ff, enter_in;
   coord_type exit_ff, exit_in;
   logic      hit_in, hit_ff;
   coord_type t_enter_ff, t_enter_in;
   coord_type t_exit_ff;

   always_comb begin
      enter_in = t_min[0];
      exit_in  = t_max[0];
      for (int k = 1; k < NUM_AXES; k++) begin
         if (t_min[k] > enter_in) begin
            enter_in = t_min[k];
         end
         if (t_max[k] < exit_in) begin
            exit_in = t_max[k];
         end
      end
   end

   // A tangent ray (entry equal to exit) is a miss.
   assign hit_in     = (enter_ff < exit_ff) && (exit_ff > COORD_ZERO);
   assign t_enter_in = (hit_in && enter_ff[COORD_WIDTH-1]) ? COORD_ZERO : enter_ff;

   always_ff @(posedge clock) begin
      if (ctrl.s4_en) begin
         enter_ff <= enter_in;
         exit_ff  <= exit_in;
      end
      if (ctrl.s5_en) begin
         hit_ff     <= hit_in;
         t_enter_ff <= t_enter_in;
         t_exit_ff  <= exit_ff;
      end
   end

   assign hit     = hit_ff;
   assign t_enter = t_enter_ff;
   assign t_exit  = t_exit_ff;

endmodule

@@ rtl/rbs_checker.sv @@
// Port-level checks for the slab test core, attached by the bind below.
// Depends on rbs_pkg and the top level ray_box_slab_intersect_core.
module rbs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rbs_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import rbs_pkg::*;

   logic      r_hit;
   coord_type r_enter, r_exit;

   assign r_hit   = rsp_tdata[0];
   assign r_enter = rsp_tdata[COORD_WIDTH:1];
   assign r_exit  = rsp_tdata[2*COORD_WIDTH:COORD_WIDTH+1];

   // A result that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A hit has a non-negative entry before a positive exit.
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_hit |-> !r_enter[COORD_WIDTH-1] && (r_enter < r_exit)
                              && (r_exit > COORD_ZERO))
      else $error("hit with inconsistent distances");

   // A miss never carries distances that would have made a hit.
   a_miss_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !r_hit |-> !((r_enter < r_exit) && (r_exit > COORD_ZERO)))
      else $error("miss with distances of a hit");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind ray_box_slab_intersect_core rbs_checker u_rbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
